FILE: rtl/fevd_pkg.sv
// Package for the frame energy voice detector: item types, register indexes,
// controller command/status structs and sizing constants.
// No dependencies; imported by every module of the block.
package fevd_pkg;

  // Sizing
  localparam int MAX_FRAME_LEN = 4096;
  localparam int COUNT_BITS    = 16;
  localparam int POS_W         = $clog2(MAX_FRAME_LEN);
  localparam int LEN_W         = $clog2(MAX_FRAME_LEN + 1);

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 12;
  localparam int FLEN_W     = 13;
  localparam int THR_W      = 63;
  localparam int PCT_W      = 15;
  localparam int OUT_CNT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  // Arithmetic widths: square is Q1.30, product Q1.46, sum held in 64 bits
  localparam int SQ_W   = 2 * SAMPLE_W - 1;
  localparam int PROD_W = SQ_W + COEF_W;
  localparam int SUM_W  = 64;

  // Voiced share scale: 100 percent in 1/256 percent units
  localparam int PCT_SCALE = 25600;
  localparam int NUM_W     = COUNT_BITS + PCT_W;

  // Register reset values
  localparam logic [FLEN_W-1:0] FRAME_LEN_RST = FLEN_W'(1103);
  localparam logic [PCT_W-1:0]  VPT_RST       = PCT_W'(12800);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH     = 2'd0,
    REG_ENERGY_THRESHOLD = 2'd1,
    REG_VOICE_PCT_THR    = 2'd2
  } cfg_reg_t;

  // Input op codes
  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_COEF_WRITE = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_recording;
    logic [COEF_IDX_W-1:0]      coef_index;
    logic [COEF_W-1:0]          coef_value;
  } in_item_t;

  typedef struct packed {
    logic                 frame_done;
    logic                 frame_low;
    logic                 report_valid;
    logic [OUT_CNT_W-1:0] frame_total;
    logic [OUT_CNT_W-1:0] low_frames;
    logic [OUT_CNT_W-1:0] voiced_frames;
    logic [PCT_W-1:0]     voiced_percent;
    logic                 voiced_verdict;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic coef_wr;
    logic mul;
    logic acc;
    logic fin;
    logic out_frame;
    logic rep_mul;
    logic rep_init;
    logic div_step;
    logic rep_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_end;
    logic eor;
    logic out_free;
    logic div_last;
  } ctrl_stat_t;

endpackage

FILE: rtl/fevd_ctrl.sv
// Controller state machine for the frame energy voice detector.
// Sequences sample, frame close and report steps; depends on fevd_pkg.
module fevd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_stall,
  input  fevd_pkg::ctrl_stat_t stat,
  output fevd_pkg::ctrl_cmd_t  cmd
);
  import fevd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_FIN  = 8'b0000_1000,
    S_RMUL = 8'b0001_0000,
    S_RINI = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_ROUT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Take an item only when idle
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_COEF_WRITE) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.eor) begin
          cmd.fin   = 1'b1;
          state_nxt = S_RMUL;
        end else if (!stat.frame_end) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.fin       = 1'b1;
          cmd.out_frame = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RMUL: begin
        cmd.rep_mul = 1'b1;
        state_nxt   = S_RINI;
      end
      S_RINI: begin
        cmd.rep_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_ROUT;
        end
      end
      S_ROUT: begin
        if (stat.out_free) begin
          cmd.rep_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/fevd_dp.sv
// Datapath for the frame energy voice detector: window store, square and
// weight multipliers, accumulator, counters, share divider and output register.
// Depends on fevd_pkg; driven by commands from fevd_ctrl.
module fevd_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fevd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fevd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  fevd_pkg::in_item_t              in_item,
  input  fevd_pkg::ctrl_cmd_t             cmd,
  output fevd_pkg::ctrl_stat_t            stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fevd_pkg::out_item_t             out_item
);
  import fevd_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int DIV_CNT_W = $clog2(PCT_W);

  // Configuration registers
  logic [FLEN_W-1:0] frame_len_r;
  logic [THR_W-1:0]  thr_r;
  logic [PCT_W-1:0]  vpt_r;

  // Sample path
  logic [COEF_W-1:0]  window_mem [MAX_FRAME_LEN];
  logic [COEF_W-1:0]  coef_r;
  logic [SQ_W-1:0]    sq_r;
  logic [PROD_W-1:0]  prod_r;
  logic [SUM_W-1:0]   sum_r;
  logic [POS_W-1:0]   pos_r;
  logic               eor_r;
  logic               done_r;
  logic               low_r;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [PROD_W-1:0]  prod_nxt;

  // Frame close
  logic [LEN_W-1:0]   act_len;
  logic [LEN_W-1:0]   pos_inc;
  logic               frame_end;
  logic               low_now;

  // Counters and report
  logic [COUNT_BITS-1:0] frame_cnt_r;
  logic [COUNT_BITS-1:0] low_cnt_r;
  logic [COUNT_BITS-1:0] voiced;
  logic [NUM_W-1:0]      num_r;
  logic [NUM_W-1:0]      rhs_r;
  logic                  verdict_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [PCT_W-1:0]      num_lo_r;
  logic [PCT_W-1:0]      quot_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [COUNT_BITS:0]   rem_ext;
  logic                  rem_ge;
  logic                  out_free;

  out_item_t out_r;
  out_item_t frame_item;
  logic      out_valid_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_LEN_RST;
      thr_r       <= '0;
      vpt_r       <= VPT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_LENGTH:     frame_len_r <= cfg_wdata[FLEN_W-1:0];
        REG_ENERGY_THRESHOLD: thr_r       <= cfg_wdata[THR_W-1:0];
        REG_VOICE_PCT_THR:    vpt_r       <= cfg_wdata[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Window store: write on coefficient item, read the current position on capture
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (32'(in_item.coef_index) < MAX_FRAME_LEN)) begin
      window_mem[POS_W'(in_item.coef_index)] <= in_item.coef_value;
    end
    if (cmd.capture) begin
      coef_r <= window_mem[pos_r];
    end
  end

  // Square on capture, weight in the next cycle
  assign sq_full  = in_item.sample * in_item.sample;
  assign prod_nxt = {{COEF_W{1'b0}}, sq_r} * {{SQ_W{1'b0}}, coef_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sq_r  <= sq_full[SQ_W-1:0];
      eor_r <= in_item.end_of_recording;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
  end

  // Clamp frame length to 1..MAX_FRAME_LEN and test for frame end
  always_comb begin
    if (frame_len_r == '0) begin
      act_len = LEN_W'(1);
    end else if (32'(frame_len_r) > MAX_FRAME_LEN) begin
      act_len = LEN_W'(MAX_FRAME_LEN);
    end else begin
      act_len = LEN_W'(frame_len_r);
    end
  end

  assign pos_inc   = LEN_W'(pos_r) + LEN_W'(1);
  assign frame_end = (pos_inc >= act_len);
  assign low_now   = (sum_r <= {1'b0, thr_r});
  assign voiced    = frame_cnt_r - low_cnt_r;

  // Accumulate, close frames, count, clear after a report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      pos_r       <= '0;
      frame_cnt_r <= '0;
      low_cnt_r   <= '0;
      done_r      <= 1'b0;
      low_r       <= 1'b0;
    end else begin
      if (cmd.acc) begin
        sum_r <= sum_r + SUM_W'(prod_r);
      end
      if (cmd.fin) begin
        if (frame_end) begin
          done_r <= 1'b1;
          low_r  <= low_now;
          if (frame_cnt_r != COUNT_MAX) begin
            frame_cnt_r <= frame_cnt_r + 1'b1;
          end
          if (low_now && (low_cnt_r != COUNT_MAX)) begin
            low_cnt_r <= low_cnt_r + 1'b1;
          end
        end else begin
          done_r <= 1'b0;
          low_r  <= 1'b0;
        end
        // Restart on a close; drop the trailing partial frame at end of recording
        if (frame_end || eor_r) begin
          sum_r <= '0;
          pos_r <= '0;
        end else begin
          pos_r <= pos_inc[POS_W-1:0];
        end
      end
      if (cmd.rep_out) begin
        frame_cnt_r <= '0;
        low_cnt_r   <= '0;
      end
    end
  end

  // Report: scale voiced count, then one quotient bit per cycle
  assign rem_ext = {rem_r, num_lo_r[PCT_W-1]};
  assign rem_ge  = (rem_ext >= {1'b0, frame_cnt_r});

  always_ff @(posedge clk) begin
    if (cmd.rep_mul) begin
      num_r <= NUM_W'(voiced) * NUM_W'(PCT_SCALE);
      rhs_r <= NUM_W'(frame_cnt_r) * NUM_W'(vpt_r);
    end
    if (cmd.rep_init) begin
      verdict_r <= (num_r >= rhs_r);
      rem_r     <= num_r[NUM_W-1:PCT_W];
      num_lo_r  <= num_r[PCT_W-1:0];
      quot_r    <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_ge ? COUNT_BITS'(rem_ext - {1'b0, frame_cnt_r})
                          : COUNT_BITS'(rem_ext);
      num_lo_r  <= {num_lo_r[PCT_W-2:0], 1'b0};
      quot_r    <= {quot_r[PCT_W-2:0], rem_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // Frame-only result: everything but the frame flags is zero
  always_comb begin
    frame_item            = '0;
    frame_item.frame_done = 1'b1;
    frame_item.frame_low  = low_now;
  end

  // Output register: load when empty or being taken, hold while stalled
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.out_frame) begin
      out_r <= frame_item;
    end else if (cmd.rep_out) begin
      out_r.frame_done     <= done_r;
      out_r.frame_low      <= low_r;
      out_r.report_valid   <= 1'b1;
      out_r.frame_total    <= OUT_CNT_W'(frame_cnt_r);
      out_r.low_frames     <= OUT_CNT_W'(low_cnt_r);
      out_r.voiced_frames  <= OUT_CNT_W'(voiced);
      out_r.voiced_percent <= (frame_cnt_r == '0) ? '0 : quot_r;
      out_r.voiced_verdict <= verdict_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_frame || cmd.rep_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Status back to the controller
  assign stat.frame_end = frame_end;
  assign stat.eor       = eor_r;
  assign stat.out_free  = out_free;
  assign stat.div_last  = (div_cnt_r == DIV_CNT_W'(PCT_W - 1));

endmodule

FILE: rtl/frame_energy_voice_detector.sv
// Frame energy voice detector, top level: controller plus datapath.
// Sample item: the weighted square runs through a square, a weight multiply and a 64-bit
// accumulate, then a frame close step registers any result, and only then is a new item taken.
// Coefficient write: no busy state. End of recording: frame close, report scaling, divider
// setup and a 15-step share divider, then the report and a new item; a held result adds its stall.
// rst_n is synchronous, active low: counters, sum, position and configuration registers return to
// reset values; the window store is not cleared and must be loaded before use.
module frame_energy_voice_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fevd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fevd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fevd_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fevd_pkg::out_item_t             out_item
);
  import fevd_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  fevd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_item.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fevd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Every emitted item closes a frame or carries a report
  a_out_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.frame_done || out_item.report_valid))
    else $error("result item with neither frame_done nor report_valid");

  // Low flag only on a completed frame
  a_low_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_item.frame_low || out_item.frame_done))
    else $error("frame_low without frame_done");

  // Report totals are consistent and the share is bounded
  a_report_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.report_valid) |->
      ((out_item.low_frames <= out_item.frame_total) &&
       (out_item.voiced_percent <= PCT_W'(PCT_SCALE))))
    else $error("report totals out of range");

  // Datapath steps never overlap
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.coef_wr, cmd.mul, cmd.acc, cmd.fin,
              cmd.rep_mul, cmd.rep_init, cmd.div_step, cmd.rep_out}))
    else $error("overlapping datapath commands");

endmodule

FILE: tb/sv/frame_energy_voice_detector_tb.sv
// Self-checking testbench for frame_energy_voice_detector: directed table, then random
// recordings checked against a built-in predictor of frame energy and recording reports.
// Depends on rtl/fevd_pkg.sv and rtl/frame_energy_voice_detector.sv.
`timescale 1ns / 1ps

module frame_energy_voice_detector_tb;
  import fevd_pkg::*;

  localparam int IDLE_PCT      = 38;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int CALM_FROM     = 470;
  localparam int CALM_TO       = 670;
  localparam int TAIL_LIMIT    = 20000;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 1;

  // One row of the directed table: a register write or an item, with an optional typed result
  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              item;
    logic                  typed;
    out_item_t             want;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;

  // Predictor state and shadow registers
  logic [COEF_W-1:0]     win_q [MAX_FRAME_LEN];
  bit                    win_set [MAX_FRAME_LEN];
  longint unsigned       sum_q    = 0;
  int unsigned           pos_q    = 0;
  longint unsigned       frames_q = 0;
  longint unsigned       lows_q   = 0;
  logic [FLEN_W-1:0]     flen_q   = FRAME_LEN_RST;
  logic [THR_W-1:0]      ethr_q   = '0;
  logic [PCT_W-1:0]      vpct_q   = VPT_RST;

  out_item_t             vad_results_due [$];
  out_item_t             oldest_due;
  plan_row_t             plan [$];

  bit                    calm       = 1'b0;
  int                    n_bad      = 0;
  int                    n_sent     = 0;
  int                    n_settings = 0;
  int                    n_frames   = 0;
  int                    n_reports  = 0;
  int                    random_start;
  int                    tail_wait;

  frame_energy_voice_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Weighted frame energy and recording totals for one item
  function automatic void vad_step(input in_item_t it, output bit hit, output out_item_t res);
    longint signed   s;
    longint unsigned sq;
    longint unsigned voiced;
    longint unsigned pct;
    int unsigned     len;
    bit              done;
    bit              low;
    hit  = 1'b0;
    res  = '0;
    done = 1'b0;
    low  = 1'b0;
    // Coefficient writes only load the window
    if (it.op == OP_COEF_WRITE) begin
      win_q[it.coef_index]   = it.coef_value;
      win_set[it.coef_index] = 1'b1;
      return;
    end
    s = it.sample;
    sq = s * s;
    sum_q += sq * longint'(win_q[pos_q]);
    pos_q++;
    len = (flen_q == 0) ? 1 : ((flen_q > MAX_FRAME_LEN) ? MAX_FRAME_LEN : flen_q);
    // Close the frame once the position reaches or passes the length
    if (pos_q >= len) begin
      done = 1'b1;
      low  = (sum_q <= longint'(ethr_q));
      if (frames_q < CNT_MAX) frames_q++;
      if (low && lows_q < CNT_MAX) lows_q++;
      sum_q = 0;
      pos_q = 0;
    end
    if (!done && !it.end_of_recording) return;
    hit = 1'b1;
    res.frame_done = done;
    res.frame_low  = low;
    // Report totals and start a new recording, dropping any partial frame
    if (it.end_of_recording) begin
      voiced = frames_q - lows_q;
      pct    = (frames_q != 0) ? (voiced * PCT_SCALE) / frames_q : 0;
      res.report_valid   = 1'b1;
      res.frame_total    = OUT_CNT_W'(frames_q);
      res.low_frames     = OUT_CNT_W'(lows_q);
      res.voiced_frames  = OUT_CNT_W'(voiced);
      res.voiced_percent = PCT_W'(pct);
      res.voiced_verdict = (voiced * PCT_SCALE) >= (frames_q * longint'(vpct_q));
      sum_q    = 0;
      pos_q    = 0;
      frames_q = 0;
      lows_q   = 0;
    end
  endfunction

  function automatic in_item_t mk_item(input logic op, input logic [SAMPLE_W-1:0] smp,
                                       input logic eor, input logic [COEF_IDX_W-1:0] idx,
                                       input logic [COEF_W-1:0] val);
    in_item_t it;
    it.op               = op;
    it.sample           = smp;
    it.end_of_recording = eor;
    it.coef_index       = idx;
    it.coef_value       = val;
    return it;
  endfunction

  function automatic out_item_t mk_out(input logic done, input logic low, input logic rv,
                                       input int tot, input int lowc, input int voiced,
                                       input int pct, input logic verdict);
    out_item_t o;
    o.frame_done     = done;
    o.frame_low      = low;
    o.report_valid   = rv;
    o.frame_total    = OUT_CNT_W'(tot);
    o.low_frames     = OUT_CNT_W'(lowc);
    o.voiced_frames  = OUT_CNT_W'(voiced);
    o.voiced_percent = PCT_W'(pct);
    o.voiced_verdict = verdict;
    return o;
  endfunction

  function automatic void plan_cfg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    plan_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = r;
    row.wdata   = d;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(input in_item_t it, input logic typed, input out_item_t w);
    plan_row_t row;
    row       = '0;
    row.item  = it;
    row.typed = typed;
    row.want  = w;
    plan.push_back(row);
  endfunction

  function automatic logic [COEF_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COEF_W'($urandom);
  endfunction

  function automatic in_item_t rand_sample_item(input logic eor);
    logic [SAMPLE_W-1:0] smp;
    int                  mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) smp = SAMPLE_W'($urandom);
    else if (mode < 8) smp = SAMPLE_W'($urandom_range(0, 127)) - 16'd64;
    else if (mode == 8) smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    else smp = '0;
    return mk_item(OP_SAMPLE, smp, eor, COEF_IDX_W'($urandom), COEF_W'($urandom));
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      n_bad++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Present one item and hold it until accepted; idle at random beforehand
  task automatic offer(input in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    calm = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);
  endtask

  // Predict and send an item, loading the window entry a sample would read if still unset
  task automatic send(input in_item_t it, input logic typed, input out_item_t want);
    in_item_t  fill;
    out_item_t got;
    bit        hit;
    if (it.op == OP_SAMPLE && !win_set[pos_q]) begin
      fill = mk_item(OP_COEF_WRITE, SAMPLE_W'($urandom), 1'($urandom), COEF_IDX_W'(pos_q),
                     rand_weight());
      vad_step(fill, hit, got);
      offer(fill);
    end
    vad_step(it, hit, got);
    if (hit) vad_results_due.push_back(typed ? want : got);
    offer(it);
  endtask

  // Drop valid, drain every due result, then let any silent work finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (vad_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_FRAME_LENGTH:     flen_q = data[FLEN_W-1:0];
      REG_ENERGY_THRESHOLD: ethr_q = data[THR_W-1:0];
      REG_VOICE_PCT_THR:    vpct_q = data[PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side stalls at random, except over the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (vad_results_due.size() == 0) begin
        n_bad++;
        $display("%0t: result expected none, got %h", $time, out_item);
      end else begin
        oldest_due = vad_results_due.pop_front();
        check_field("frame_done", oldest_due.frame_done, out_item.frame_done);
        check_field("frame_low", oldest_due.frame_low, out_item.frame_low);
        check_field("report_valid", oldest_due.report_valid, out_item.report_valid);
        check_field("frame_total", oldest_due.frame_total, out_item.frame_total);
        check_field("low_frames", oldest_due.low_frames, out_item.low_frames);
        check_field("voiced_frames", oldest_due.voiced_frames, out_item.voiced_frames);
        check_field("voiced_percent", oldest_due.voiced_percent, out_item.voiced_percent);
        check_field("voiced_verdict", oldest_due.voiced_verdict, out_item.voiced_verdict);
        if (oldest_due.frame_done) n_frames++;
        if (oldest_due.report_valid) n_reports++;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int                    r;
    int                    eff;
    int                    nsamp;
    bit                    end_flag;
    logic                  eor;
    logic [FLEN_W-1:0]     flen;
    logic [CFG_DATA_W-1:0] data;

    // Directed table: reset report, extremes, threshold edges, partial frame, length change
    plan_item(mk_item(OP_COEF_WRITE, '0, 1'b0, '0, '0), 1'b0, '0);
    plan_item(mk_item(OP_SAMPLE, '0, 1'b1, '0, '0), 1'b1, mk_out(0, 0, 1, 0, 0, 0, 0, 1));
    plan_cfg(REG_FRAME_LENGTH, '0);
    plan_cfg(REG_ENERGY_THRESHOLD, '0);
    plan_item(mk_item(OP_COEF_WRITE, '0, 1'b0, '0, 16'hFFFF), 1'b0, '0);
    plan_item(mk_item(OP_SAMPLE, 16'h8000, 1'b0, '0, '0), 1'b1, mk_out(1, 0, 0, 0, 0, 0, 0, 0));
    plan_item(mk_item(OP_SAMPLE, 16'h0000, 1'b0, '0, '0), 1'b1, mk_out(1, 1, 0, 0, 0, 0, 0, 0));
    plan_item(mk_item(OP_SAMPLE, 16'h7FFF, 1'b1, '0, '0), 1'b1,
              mk_out(1, 0, 1, 3, 1, 2, 17066, 1));
    plan_cfg(REG_ENERGY_THRESHOLD, {THR_W{1'b1}});
    plan_cfg(REG_VOICE_PCT_THR, CFG_DATA_W'(PCT_SCALE));
    plan_item(mk_item(OP_SAMPLE, 16'd12345, 1'b1, '0, '0), 1'b1,
              mk_out(1, 1, 1, 1, 1, 0, 0, 0));
    plan_cfg(REG_VOICE_PCT_THR, CFG_DATA_W'(32767));
    plan_cfg(REG_ENERGY_THRESHOLD, '0);
    plan_item(mk_item(OP_SAMPLE, 16'hFFFF, 1'b1, '0, '0), 1'b1,
              mk_out(1, 0, 1, 1, 0, 1, 25600, 0));
    plan_cfg(REG_FRAME_LENGTH, CFG_DATA_W'(8191));
    plan_cfg(REG_VOICE_PCT_THR, '0);
    plan_item(mk_item(OP_COEF_WRITE, '0, 1'b0, 12'd1, 16'd1), 1'b0, '0);
    plan_item(mk_item(OP_COEF_WRITE, '0, 1'b0, 12'd2, 16'h1234), 1'b0, '0);
    plan_item(mk_item(OP_COEF_WRITE, '0, 1'b1, 12'd4095, 16'h8000), 1'b0, '0);
    plan_item(mk_item(OP_SAMPLE, 16'd100, 1'b0, '0, '0), 1'b0, '0);
    plan_item(mk_item(OP_SAMPLE, -16'sd100, 1'b0, '0, '0), 1'b0, '0);
    plan_item(mk_item(OP_SAMPLE, 16'd7, 1'b1, '0, '0), 1'b1, mk_out(0, 0, 1, 0, 0, 0, 0, 1));
    plan_cfg(REG_FRAME_LENGTH, CFG_DATA_W'(3));
    plan_cfg(REG_ENERGY_THRESHOLD, CFG_DATA_W'(64'd1_000_000_000_000));
    plan_item(mk_item(OP_SAMPLE, -16'sd20000, 1'b0, '0, '0), 1'b0, '0);
    plan_item(mk_item(OP_SAMPLE, 16'sd20000, 1'b0, '0, '0), 1'b0, '0);
    plan_cfg(REG_FRAME_LENGTH, CFG_DATA_W'(2));
    plan_item(mk_item(OP_SAMPLE, 16'd5, 1'b0, '0, '0), 1'b0, '0);
    plan_item(mk_item(OP_SAMPLE, -16'sd5, 1'b1, '0, '0), 1'b0, '0);

    // Hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].wdata);
        n_settings++;
      end else begin
        send(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // Random recordings: one register setting per stretch, mostly whole frames
    random_start = n_sent;
    while (n_sent - random_start < RANDOM_ITEMS) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 65) flen = FLEN_W'($urandom_range(1, 8));
      else if (r < 85) flen = FLEN_W'($urandom_range(9, 40));
      else if (r < 90) flen = '0;
      else if (r < 94) flen = FLEN_W'(MAX_FRAME_LEN);
      else if (r < 96) flen = '1;
      else flen = FLEN_W'($urandom_range(41, 8191));
      data = CFG_DATA_W'(flen);
      if ($urandom_range(0, 3) == 0)
        data[CFG_DATA_W-1:FLEN_W] = (CFG_DATA_W-FLEN_W)'({$urandom, $urandom});
      write_reg(REG_FRAME_LENGTH, data);
      r = $urandom_range(0, 9);
      if (r == 0) data = '0;
      else if (r == 1) data = '1;
      else data = CFG_DATA_W'({$urandom, $urandom} >> $urandom_range(1, 40));
      write_reg(REG_ENERGY_THRESHOLD, data);
      r = $urandom_range(0, 9);
      if (r < 8) data = CFG_DATA_W'($urandom_range(0, PCT_SCALE));
      else if (r == 8) data = $urandom_range(0, 1) ? CFG_DATA_W'(PCT_SCALE) : '0;
      else data = CFG_DATA_W'($urandom_range(PCT_SCALE + 1, 32767));
      if ($urandom_range(0, 3) == 0)
        data[CFG_DATA_W-1:PCT_W] = (CFG_DATA_W-PCT_W)'({$urandom, $urandom});
      write_reg(REG_VOICE_PCT_THR, data);
      n_settings += 3;

      eff = (flen == 0) ? 1 : ((flen > MAX_FRAME_LEN) ? MAX_FRAME_LEN : flen);
      if (eff <= 40) nsamp = $urandom_range(1, 5) * eff + $urandom_range(0, eff - 1);
      else nsamp = $urandom_range(1, 8);
      end_flag = ($urandom_range(0, 9) < 7);
      for (int k = 0; k < nsamp; k++) begin
        // Scatter stray window writes and early recording ends
        if ($urandom_range(0, 99) < 8)
          send(mk_item(OP_COEF_WRITE, SAMPLE_W'($urandom), 1'($urandom), COEF_IDX_W'($urandom),
                       rand_weight()), 1'b0, '0);
        eor = ((k == nsamp - 1) && end_flag) || ($urandom_range(0, 99) < 3);
        send(rand_sample_item(eor), 1'b0, '0);
      end
    end

    // Drain, then wait out the longest silent work
    @(negedge clk);
    in_valid <= 1'b0;
    tail_wait = 0;
    while (vad_results_due.size() != 0 && tail_wait < TAIL_LIMIT) begin
      @(posedge clk);
      tail_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (vad_results_due.size() != 0) begin
      n_bad++;
      $display("%0t: %0d results expected, none arrived", $time, vad_results_due.size());
    end

    $display("sent %0d items across %0d register writes", n_sent, n_settings);
    $display("checked %0d completed frames and %0d recording reports", n_frames, n_reports);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: frame_energy_voice_detector.f
rtl/fevd_pkg.sv
rtl/fevd_ctrl.sv
rtl/fevd_dp.sv
rtl/frame_energy_voice_detector.sv
tb/sv/frame_energy_voice_detector_tb.sv
